// ----- hdl/quaternion_arithmetic_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit assertion macros
// Concurrent check wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH
`define QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define QAU_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("quaternion unit check failed");
// consequent holds in the same cycle
`define QAU_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("quaternion unit check failed");
// consequent holds in the next cycle
`define QAU_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("quaternion unit check failed");
`else
`define QAU_ASSERT(lbl, cond)
`define QAU_IMPLIES(lbl, ante, cons)
`define QAU_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/qau_pkg.sv -----
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit package
// Number format, pipeline stage map, operation codes and shared arithmetic.
// ----------------------------------------------------------------------------
package qau_pkg;

  // Q3.12 words
  localparam int WORD_BITS = 16;
  localparam int FRAC_BITS = 12;

  // rounded product and four-term sum widths
  localparam int PROD_BITS = 2 * WORD_BITS - FRAC_BITS + 2;
  localparam int SUM_BITS  = PROD_BITS + 2;

  // norm datapath
  localparam int SQ_BITS   = 2 * WORD_BITS - 1;
  localparam int SSQ_BITS  = SQ_BITS + 2;
  localparam int ROOT_BITS = WORD_BITS + 1;
  localparam int REM_BITS  = 2 * ROOT_BITS;

  // normalize divider: quotient never exceeds 2^FRAC_BITS
  localparam int DIV_STEPS = FRAC_BITS + 2;
  localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
  localparam int DREM_BITS = ROOT_BITS + 1;

  // stage map
  localparam int ST_PROD1    = 1;
  localparam int ST_HAM1     = 2;
  localparam int ST_PROD2    = 3;
  localparam int ST_ROT      = 4;
  localparam int ST_SQ0      = 3;
  localparam int ST_RND      = ST_SQ0 + ROOT_BITS;
  localparam int ST_OUT      = ST_RND + DIV_STEPS + 1;
  localparam int NUM_STAGES  = ST_OUT;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [WORD_BITS:0]   wordx_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [SUM_BITS-1:0]  sum_t;
  typedef word_t quat_t [4];
  typedef prod_t prod_mat_t [4][4];

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_ADDS  = 4'd2,
    OP_SUBS  = 4'd3,
    OP_MUL   = 4'd4,
    OP_VMUL  = 4'd5,
    OP_SCALE = 4'd6,
    OP_CONJ  = 4'd7,
    OP_ROT   = 4'd8,
    OP_NORM  = 4'd9,
    OP_NRMZ  = 4'd10,
    OP_EQ    = 4'd11
  } op_t;

  localparam sum_t SUM_WMAX = sum_t'((longint'(1) <<< (WORD_BITS - 1)) - longint'(1));
  localparam sum_t SUM_WMIN = -SUM_WMAX - sum_t'(1);

  // product rounded half up to FRAC_BITS fraction bits
  function automatic prod_t mulr(input word_t a, input wordx_t b);
    logic signed [2*WORD_BITS:0] full;
    full = a * b;
    full = full + ((2 * WORD_BITS + 1)'(1) << (FRAC_BITS - 1));
    return prod_t'(full >>> FRAC_BITS);
  endfunction

  // clamp to the word range
  function automatic word_t sat_word(input sum_t v);
    if (v > SUM_WMAX) begin
      return word_t'(SUM_WMAX);
    end else if (v < SUM_WMIN) begin
      return word_t'(SUM_WMIN);
    end
    return word_t'(v);
  endfunction

  function automatic logic sat_flag(input sum_t v);
    return (v > SUM_WMAX) || (v < SUM_WMIN);
  endfunction

  // one component of a Hamilton product from its rounded partial products
  function automatic sum_t ham(input prod_mat_t m, input logic [1:0] c);
    case (c)
      2'd0: return sum_t'(m[0][0]) - sum_t'(m[1][1]) - sum_t'(m[2][2]) - sum_t'(m[3][3]);
      2'd1: return sum_t'(m[0][1]) + sum_t'(m[1][0]) + sum_t'(m[2][3]) - sum_t'(m[3][2]);
      2'd2: return sum_t'(m[0][2]) - sum_t'(m[1][3]) + sum_t'(m[2][0]) + sum_t'(m[3][1]);
      default: return sum_t'(m[0][3]) + sum_t'(m[1][2]) - sum_t'(m[2][1]) + sum_t'(m[3][0]);
    endcase
  endfunction

endpackage

// ----- hdl/quaternion_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// Quaternion arithmetic unit
// Pipelined Q3.12 quaternion add, product, rotate, norm and normalize.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries operation, p_w..p_z, q_w..q_z.
//   Output channel out_valid/out_ready carries r_w..r_z, is_equal,
//   saturated and zero_norm. Each accepted item gives exactly one result.
//   Every operation passes through 35 register stages: two product
//   stages, one square-root bit per stage (17 stages), one rounding
//   stage, one quotient bit per stage (14 stages) of the normalize
//   divider, and the output register.
//   Throughput is one item per cycle; the whole pipe advances together.
//   When the receiver holds out_ready low with a result waiting, the pipe
//   freezes and in_ready drops; nothing is lost or repeated, and empty
//   slots keep moving as long as the output register is empty.
//   Reset clears the valid bits only; no clearing pass is needed.
//   Unused operation codes give all-zero results.
// ----------------------------------------------------------------------------
`include "quaternion_arithmetic_unit_assert.svh"

module quaternion_arithmetic_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           operation,
  input  qau_pkg::word_t       p_w,
  input  qau_pkg::word_t       p_x,
  input  qau_pkg::word_t       p_y,
  input  qau_pkg::word_t       p_z,
  input  qau_pkg::word_t       q_w,
  input  qau_pkg::word_t       q_x,
  input  qau_pkg::word_t       q_y,
  input  qau_pkg::word_t       q_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output qau_pkg::word_t       r_w,
  output qau_pkg::word_t       r_x,
  output qau_pkg::word_t       r_y,
  output qau_pkg::word_t       r_z,
  output logic                 is_equal,
  output logic                 saturated,
  output logic                 zero_norm
);

  logic adv;

  // carried per stage
  logic                vld   [1:qau_pkg::NUM_STAGES];
  logic [3:0]          op_s  [1:qau_pkg::NUM_STAGES];
  qau_pkg::quat_t      p_s   [1:qau_pkg::NUM_STAGES];
  qau_pkg::quat_t      r_s   [1:qau_pkg::NUM_STAGES];
  logic                sat_s [1:qau_pkg::NUM_STAGES];
  logic                eq_s  [1:qau_pkg::NUM_STAGES];
  logic                zn_s  [1:qau_pkg::NUM_STAGES];
  logic [3:0]          op_next  [1:qau_pkg::NUM_STAGES];
  qau_pkg::quat_t      p_next   [1:qau_pkg::NUM_STAGES];
  qau_pkg::quat_t      r_next   [1:qau_pkg::NUM_STAGES];
  logic                sat_next [1:qau_pkg::NUM_STAGES];
  logic                eq_next  [1:qau_pkg::NUM_STAGES];
  logic                zn_next  [1:qau_pkg::NUM_STAGES];

  // input side
  qau_pkg::quat_t      in_p;
  qau_pkg::quat_t      in_q;
  qau_pkg::wordx_t     bq [4];
  logic signed [2*qau_pkg::WORD_BITS-1:0] sqf [4];

  // product and sum stages
  qau_pkg::quat_t      q1;
  qau_pkg::prod_mat_t  prod1, prod1_next;
  logic [qau_pkg::SQ_BITS-1:0] sq1 [4];
  logic [qau_pkg::SQ_BITS-1:0] sq1_next [4];
  qau_pkg::sum_t       h1 [4];
  qau_pkg::sum_t       h2 [4];
  logic                tsat;
  qau_pkg::quat_t      t2, t2_next;
  logic [qau_pkg::SSQ_BITS-1:0] ssq2, ssq2_next;
  qau_pkg::wordx_t     cj [4];
  qau_pkg::prod_mat_t  prod3, prod3_next;

  // square root, one result bit per stage
  logic [qau_pkg::REM_BITS-1:0]  sq_rem       [qau_pkg::ROOT_BITS];
  logic [qau_pkg::ROOT_BITS-1:0] sq_root      [qau_pkg::ROOT_BITS];
  logic [qau_pkg::REM_BITS-1:0]  sq_rem_next  [qau_pkg::ROOT_BITS];
  logic [qau_pkg::ROOT_BITS-1:0] sq_root_next [qau_pkg::ROOT_BITS];

  // normalize divider, one quotient bit per stage, four lanes
  logic [qau_pkg::ROOT_BITS-1:0] dv_n       [qau_pkg::DIV_STEPS+1];
  logic [qau_pkg::DREM_BITS-1:0] dv_rem     [qau_pkg::DIV_STEPS+1][4];
  logic [qau_pkg::DIV_STEPS-1:0] dv_low     [qau_pkg::DIV_STEPS+1][4];
  logic [qau_pkg::DIV_STEPS-1:0] dv_quot    [qau_pkg::DIV_STEPS+1][4];
  logic [qau_pkg::ROOT_BITS-1:0] dv_n_next    [qau_pkg::DIV_STEPS+1];
  logic [qau_pkg::DREM_BITS-1:0] dv_rem_next  [qau_pkg::DIV_STEPS+1][4];
  logic [qau_pkg::DIV_STEPS-1:0] dv_low_next  [qau_pkg::DIV_STEPS+1][4];
  logic [qau_pkg::DIV_STEPS-1:0] dv_quot_next [qau_pkg::DIV_STEPS+1][4];
  logic [qau_pkg::ROOT_BITS-1:0] nrm;
  logic [qau_pkg::WORD_BITS-1:0] mag [4];
  logic [qau_pkg::NUM_BITS-1:0]  num [4];

  // advance the whole pipe unless a result waits at the output
  assign adv      = !vld[qau_pkg::NUM_STAGES] || out_ready;
  assign in_ready = adv;

  // gather operands; vector forms drop the scalar of q
  always_comb begin
    in_p[0] = p_w;
    in_p[1] = p_x;
    in_p[2] = p_y;
    in_p[3] = p_z;
    in_q[0] = q_w;
    in_q[1] = q_x;
    in_q[2] = q_y;
    in_q[3] = q_z;
    for (int j = 0; j < 4; j++) begin
      bq[j] = qau_pkg::wordx_t'(in_q[j]);
    end
    if (operation == qau_pkg::OP_VMUL || operation == qau_pkg::OP_ROT) begin
      bq[0] = '0;
    end
  end

  // first products and squares
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod1_next[i][j] = qau_pkg::mulr(in_p[i], bq[j]);
      end
      sqf[i]      = in_p[i] * in_p[i];
      sq1_next[i] = sqf[i][qau_pkg::SQ_BITS-1:0];
    end
  end

  // first Hamilton sums and sum of squares
  always_comb begin
    tsat      = 1'b0;
    ssq2_next = '0;
    for (int c = 0; c < 4; c++) begin
      h1[c]      = qau_pkg::ham(prod1, 2'(c));
      t2_next[c] = qau_pkg::sat_word(h1[c]);
      tsat       = tsat | qau_pkg::sat_flag(h1[c]);
      ssq2_next  = ssq2_next + qau_pkg::SSQ_BITS'(sq1[c]);
    end
  end

  // second products against the conjugate of p
  always_comb begin
    cj[0] = qau_pkg::wordx_t'(p_s[qau_pkg::ST_HAM1][0]);
    for (int j = 1; j < 4; j++) begin
      cj[j] = -qau_pkg::wordx_t'(p_s[qau_pkg::ST_HAM1][j]);
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod3_next[i][j] = qau_pkg::mulr(t2[i], cj[j]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      h2[c] = qau_pkg::ham(prod3, 2'(c));
    end
  end

  // square root recurrence: try each result bit from the top
  always_comb begin
    logic [qau_pkg::REM_BITS-1:0]  rin;
    logic [qau_pkg::REM_BITS-1:0]  trial;
    logic [qau_pkg::ROOT_BITS-1:0] oin;
    for (int j = 0; j < qau_pkg::ROOT_BITS; j++) begin
      if (j == 0) begin
        rin = qau_pkg::REM_BITS'(ssq2);
        oin = '0;
      end else begin
        rin = sq_rem[j-1];
        oin = sq_root[j-1];
      end
      trial = (qau_pkg::REM_BITS'(oin) << (qau_pkg::ROOT_BITS - j))
            + (qau_pkg::REM_BITS'(1) << (2 * (qau_pkg::ROOT_BITS - 1 - j)));
      if (rin >= trial) begin
        sq_rem_next[j]  = rin - trial;
        sq_root_next[j] = oin | (qau_pkg::ROOT_BITS'(1) << (qau_pkg::ROOT_BITS - 1 - j));
      end else begin
        sq_rem_next[j]  = rin;
        sq_root_next[j] = oin;
      end
    end
  end

  // round the root, then set up and run the divider lanes
  always_comb begin
    logic [qau_pkg::DREM_BITS-1:0] rs;
    nrm = sq_root[qau_pkg::ROOT_BITS-1]
        + qau_pkg::ROOT_BITS'(sq_rem[qau_pkg::ROOT_BITS-1]
                              > qau_pkg::REM_BITS'(sq_root[qau_pkg::ROOT_BITS-1]));
    dv_n_next[0] = nrm;
    for (int i = 0; i < 4; i++) begin
      if (p_s[qau_pkg::ST_RND-1][i] < 0) begin
        mag[i] = -p_s[qau_pkg::ST_RND-1][i];
      end else begin
        mag[i] = p_s[qau_pkg::ST_RND-1][i];
      end
      num[i] = (qau_pkg::NUM_BITS'(mag[i]) << qau_pkg::FRAC_BITS)
             + qau_pkg::NUM_BITS'(nrm >> 1);
      dv_rem_next[0][i]  = qau_pkg::DREM_BITS'(num[i] >> qau_pkg::DIV_STEPS);
      dv_low_next[0][i]  = num[i][qau_pkg::DIV_STEPS-1:0];
      dv_quot_next[0][i] = '0;
    end
    for (int k = 1; k <= qau_pkg::DIV_STEPS; k++) begin
      dv_n_next[k] = dv_n[k-1];
      for (int i = 0; i < 4; i++) begin
        dv_low_next[k][i] = dv_low[k-1][i];
        rs = {dv_rem[k-1][i][qau_pkg::DREM_BITS-2:0],
              dv_low[k-1][i][qau_pkg::DIV_STEPS-k]};
        if (rs >= qau_pkg::DREM_BITS'(dv_n[k-1])) begin
          dv_rem_next[k][i]  = rs - qau_pkg::DREM_BITS'(dv_n[k-1]);
          dv_quot_next[k][i] = {dv_quot[k-1][i][qau_pkg::DIV_STEPS-2:0], 1'b1};
        end else begin
          dv_rem_next[k][i]  = rs;
          dv_quot_next[k][i] = {dv_quot[k-1][i][qau_pkg::DIV_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  // per-stage result update; stages without work pass their item on
  always_comb begin
    qau_pkg::sum_t qv;
    qau_pkg::sum_t sv;
    logic          eq_all;
    qv     = '0;
    sv     = '0;
    eq_all = 1'b1;
    for (int i = 0; i < 4; i++) begin
      eq_all = eq_all & (in_p[i] == in_q[i]);
    end
    op_next[1]  = operation;
    p_next[1]   = in_p;
    sat_next[1] = 1'b0;
    eq_next[1]  = (operation == qau_pkg::OP_EQ) && eq_all;
    zn_next[1]  = 1'b0;
    for (int i = 0; i < 4; i++) begin
      r_next[1][i] = '0;
    end
    for (int k = 2; k <= qau_pkg::NUM_STAGES; k++) begin
      op_next[k]  = op_s[k-1];
      p_next[k]   = p_s[k-1];
      r_next[k]   = r_s[k-1];
      sat_next[k] = sat_s[k-1];
      eq_next[k]  = eq_s[k-1];
      zn_next[k]  = zn_s[k-1];
    end

    // element-wise operations and the first Hamilton product
    case (op_s[qau_pkg::ST_PROD1]) inside
      qau_pkg::OP_ADD: begin
        for (int i = 0; i < 4; i++) begin
          sv = qau_pkg::sum_t'(p_s[1][i]) + qau_pkg::sum_t'(q1[i]);
          r_next[2][i] = qau_pkg::sat_word(sv);
          sat_next[2]  = sat_next[2] | qau_pkg::sat_flag(sv);
        end
      end
      qau_pkg::OP_SUB: begin
        for (int i = 0; i < 4; i++) begin
          sv = qau_pkg::sum_t'(p_s[1][i]) - qau_pkg::sum_t'(q1[i]);
          r_next[2][i] = qau_pkg::sat_word(sv);
          sat_next[2]  = sat_next[2] | qau_pkg::sat_flag(sv);
        end
      end
      qau_pkg::OP_ADDS, qau_pkg::OP_SUBS: begin
        if (op_s[1] == qau_pkg::OP_ADDS) begin
          sv = qau_pkg::sum_t'(p_s[1][0]) + qau_pkg::sum_t'(q1[0]);
        end else begin
          sv = qau_pkg::sum_t'(p_s[1][0]) - qau_pkg::sum_t'(q1[0]);
        end
        r_next[2][0] = qau_pkg::sat_word(sv);
        sat_next[2]  = qau_pkg::sat_flag(sv);
        for (int i = 1; i < 4; i++) begin
          r_next[2][i] = p_s[1][i];
        end
      end
      qau_pkg::OP_MUL, qau_pkg::OP_VMUL: begin
        r_next[2]   = t2_next;
        sat_next[2] = tsat;
      end
      qau_pkg::OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          sv = qau_pkg::sum_t'(prod1[i][0]);
          r_next[2][i] = qau_pkg::sat_word(sv);
          sat_next[2]  = sat_next[2] | qau_pkg::sat_flag(sv);
        end
      end
      qau_pkg::OP_CONJ: begin
        r_next[2][0] = p_s[1][0];
        for (int i = 1; i < 4; i++) begin
          sv = -qau_pkg::sum_t'(p_s[1][i]);
          r_next[2][i] = qau_pkg::sat_word(sv);
          sat_next[2]  = sat_next[2] | qau_pkg::sat_flag(sv);
        end
      end
      qau_pkg::OP_ROT: begin
        sat_next[2] = tsat;
      end
      default: begin
      end
    endcase

    // rotate: second product, scalar part dropped after its clamp check
    if (op_s[qau_pkg::ST_ROT-1] == qau_pkg::OP_ROT) begin
      r_next[qau_pkg::ST_ROT][0] = '0;
      for (int c = 0; c < 4; c++) begin
        sat_next[qau_pkg::ST_ROT] = sat_next[qau_pkg::ST_ROT] | qau_pkg::sat_flag(h2[c]);
        if (c != 0) begin
          r_next[qau_pkg::ST_ROT][c] = qau_pkg::sat_word(h2[c]);
        end
      end
    end

    // norm result and zero check
    if (op_s[qau_pkg::ST_RND-1] == qau_pkg::OP_NORM) begin
      sv = qau_pkg::sum_t'(nrm);
      r_next[qau_pkg::ST_RND][0] = qau_pkg::sat_word(sv);
      sat_next[qau_pkg::ST_RND]  = qau_pkg::sat_flag(sv);
    end
    if (op_s[qau_pkg::ST_RND-1] == qau_pkg::OP_NRMZ) begin
      zn_next[qau_pkg::ST_RND] = (nrm == '0);
    end

    // normalize: restore the sign of each quotient
    if (op_s[qau_pkg::ST_OUT-1] == qau_pkg::OP_NRMZ && !zn_s[qau_pkg::ST_OUT-1]) begin
      for (int i = 0; i < 4; i++) begin
        qv = qau_pkg::sum_t'(dv_quot[qau_pkg::DIV_STEPS][i]);
        if (p_s[qau_pkg::ST_OUT-1][i] < 0) begin
          sv = -qv;
        end else begin
          sv = qv;
        end
        r_next[qau_pkg::ST_OUT][i] = qau_pkg::sat_word(sv);
        sat_next[qau_pkg::ST_OUT]  = sat_next[qau_pkg::ST_OUT] | qau_pkg::sat_flag(sv);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= qau_pkg::NUM_STAGES; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (adv) begin
      vld[1] <= in_valid;
      for (int k = 2; k <= qau_pkg::NUM_STAGES; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k <= qau_pkg::NUM_STAGES; k++) begin
        op_s[k]  <= op_next[k];
        p_s[k]   <= p_next[k];
        r_s[k]   <= r_next[k];
        sat_s[k] <= sat_next[k];
        eq_s[k]  <= eq_next[k];
        zn_s[k]  <= zn_next[k];
      end
      q1    <= in_q;
      prod1 <= prod1_next;
      sq1   <= sq1_next;
      t2    <= t2_next;
      ssq2  <= ssq2_next;
      prod3 <= prod3_next;
      sq_rem  <= sq_rem_next;
      sq_root <= sq_root_next;
      dv_n    <= dv_n_next;
      dv_rem  <= dv_rem_next;
      dv_low  <= dv_low_next;
      dv_quot <= dv_quot_next;
    end
  end

  // output register is the last stage
  assign out_valid = vld[qau_pkg::NUM_STAGES];
  assign r_w       = r_s[qau_pkg::NUM_STAGES][0];
  assign r_x       = r_s[qau_pkg::NUM_STAGES][1];
  assign r_y       = r_s[qau_pkg::NUM_STAGES][2];
  assign r_z       = r_s[qau_pkg::NUM_STAGES][3];
  assign is_equal  = eq_s[qau_pkg::NUM_STAGES];
  assign saturated = sat_s[qau_pkg::NUM_STAGES];
  assign zero_norm = zn_s[qau_pkg::NUM_STAGES];

  // checks
  `QAU_IMPLIES(a_zero_norm_clear, out_valid && zero_norm, (r_w | r_x | r_y | r_z) == '0)
  `QAU_ASSERT(a_flags_exclusive, !(out_valid && is_equal && zero_norm))
  `QAU_IMPLIES(a_rot_scalar, out_valid && op_s[qau_pkg::NUM_STAGES] == qau_pkg::OP_ROT, r_w == 0)
  `QAU_NEXT(a_enter, in_valid && in_ready, vld[1])

endmodule
